// ----- rtl/core/sequenced_ring_queue_assert.svh -----
// Assertion macros used by the sequenced ring queue top level.
`ifndef SEQUENCED_RING_QUEUE_ASSERT_SVH
`define SEQUENCED_RING_QUEUE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/srq_pkg.sv -----
// Package with the shared constants, types and helpers of the sequenced ring queue.
`timescale 1ns / 1ps

package srq_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int unsigned SIZE_W    = SLOT_AW + 1;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned LG_W      = 4;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [LG_W-1:0] RING_LG_RESET = LG_W'(10);
  localparam logic [LG_W-1:0] RING_LG_MIN   = LG_W'(1);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic REG_RING_SIZE_LOG2 = 1'b0;

  typedef struct packed {
    logic accept;
    logic load_out;
  } srq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } srq_status_t;

  function automatic logic [LG_W-1:0] eff_ring_lg(input logic [LG_W-1:0] lg);
    logic [LG_W-1:0] res;
    res = lg;
    if (lg < RING_LG_MIN) begin
      res = RING_LG_MIN;
    end else if (lg > LG_W'(SLOT_AW)) begin
      res = LG_W'(SLOT_AW);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/srq_ctrl.sv -----
// Controller state machine that sequences each queue operation through the datapath.
`timescale 1ns / 1ps

module srq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srq_pkg::srq_status_t status_i,
  output srq_pkg::srq_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q;
  logic state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/srq_datapath.sv -----
// Datapath with the position counters, size register, payload memory and result register.
`timescale 1ns / 1ps

module srq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srq_pkg::srq_cmd_t              cmd_i,
  output srq_pkg::srq_status_t           status_o,
  input  logic                           kind_i,
  input  logic [srq_pkg::DATA_W-1:0]     push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           success_o,
  output logic [srq_pkg::DATA_W-1:0]     pop_value_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srq_pkg::ADDR_W-1:0]     paddr,
  input  logic [srq_pkg::PDATA_W-1:0]    pwdata,
  output logic [srq_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [srq_pkg::LG_W-1:0]    ring_lg_q;
  logic [srq_pkg::POS_W-1:0]   head_q;
  logic [srq_pkg::POS_W-1:0]   tail_q;
  logic [srq_pkg::DATA_W-1:0]  payload_mem [srq_pkg::MAX_SLOTS];
  logic [srq_pkg::DATA_W-1:0]  rd_data_q;
  logic                        op_ok_q;
  logic                        op_deq_q;
  logic                        out_valid_q;
  logic                        out_success_q;
  logic [srq_pkg::DATA_W-1:0]  out_pop_q;

  logic [srq_pkg::LG_W-1:0]    ring_lg;
  logic [srq_pkg::SIZE_W-1:0]  ring_size;
  logic [srq_pkg::SLOT_AW-1:0] slot_mask;
  logic [srq_pkg::SLOT_AW-1:0] head_idx;
  logic [srq_pkg::SLOT_AW-1:0] tail_idx;
  logic [srq_pkg::POS_W-1:0]   fill;
  logic                        full;
  logic                        empty;
  logic                        cfg_wr;
  logic                        do_enq;
  logic                        do_deq;

  // Tags are implied by the positions: a slot is free for head exactly while
  // fewer than ring_size items are held, and filled for tail while any are.
  assign ring_lg   = srq_pkg::eff_ring_lg(ring_lg_q);
  assign ring_size = srq_pkg::SIZE_W'(1) << ring_lg;
  assign slot_mask = srq_pkg::SLOT_AW'(ring_size - srq_pkg::SIZE_W'(1));
  assign head_idx  = head_q[srq_pkg::SLOT_AW-1:0] & slot_mask;
  assign tail_idx  = tail_q[srq_pkg::SLOT_AW-1:0] & slot_mask;
  assign fill      = head_q - tail_q;
  assign full      = (fill == srq_pkg::POS_W'(ring_size));
  assign empty     = (head_q == tail_q);

  assign do_enq = cmd_i.accept && (kind_i == srq_pkg::KIND_ENQ) && !full;
  assign do_deq = cmd_i.accept && (kind_i == srq_pkg::KIND_DEQ) && !empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[srq_pkg::ADDR_W-1] == srq_pkg::REG_RING_SIZE_LOG2);
  assign prdata = (paddr[srq_pkg::ADDR_W-1] == srq_pkg::REG_RING_SIZE_LOG2)
                  ? srq_pkg::PDATA_W'(ring_lg_q) : '0;

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign success_o         = out_success_q;
  assign pop_value_o       = out_pop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_lg_q <= srq_pkg::RING_LG_RESET;
      head_q    <= '0;
      tail_q    <= '0;
    end else if (cfg_wr) begin
      ring_lg_q <= pwdata[srq_pkg::LG_W-1:0];
      head_q    <= '0;
      tail_q    <= '0;
    end else begin
      if (do_enq) begin
        head_q <= head_q + srq_pkg::POS_W'(1);
      end
      if (do_deq) begin
        tail_q <= tail_q + srq_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      payload_mem[head_idx] <= push_value_i;
    end
    if (do_deq) begin
      rd_data_q <= payload_mem[tail_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_ok_q  <= do_enq || do_deq;
      op_deq_q <= (kind_i == srq_pkg::KIND_DEQ);
    end
    if (cmd_i.load_out) begin
      out_success_q <= op_ok_q;
      out_pop_q     <= (op_ok_q && op_deq_q) ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/sequenced_ring_queue.sv -----
// Top level of the sequenced ring queue: controller, datapath and assertions.
`timescale 1ns / 1ps

// Bounded ring queue of up to 1024 slots of 64-bit data, sized by the
// ring_size_log2 register (values below 1 act as 1, above 10 as 10). Each
// enqueue or dequeue transfer runs in order: the accept cycle checks
// full or empty against the 32-bit head and tail counters and performs the
// single payload memory access; the execute state loads the result register
// from the registered memory read once the output is not busy. The result
// register lets a new transfer be accepted while the previous result still
// waits. A write to the size register empties the ring at once by clearing
// both counters; stored payloads are kept and no clearing pass is needed.
`include "sequenced_ring_queue_assert.svh"

module sequenced_ring_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [srq_pkg::DATA_W-1:0]     push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           success_o,
  output logic [srq_pkg::DATA_W-1:0]     pop_value_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srq_pkg::ADDR_W-1:0]     paddr,
  input  logic [srq_pkg::PDATA_W-1:0]    pwdata,
  output logic [srq_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  srq_pkg::srq_cmd_t    cmd;
  srq_pkg::srq_status_t status;

  srq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (kind_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .success_o    (success_o),
    .pop_value_o  (pop_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  `SRQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `SRQ_ASSERT_SAME(a_fail_pops_zero, out_valid_o && !success_o, pop_value_o == '0, "nonzero pop on failure")
  `SRQ_ASSERT_SAME(a_result_after_exec, $rose(out_valid_o), $past(!in_ready_o), "result without execution")

endmodule

// ----- tb/sv/srq_checker.sv -----
// Checker for the sequenced ring queue: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module srq_checker
  import srq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                kind_i,
  input  logic [DATA_W-1:0]   push_value_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                success_i,
  input  logic [DATA_W-1:0]   pop_value_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_count_o
);

  typedef struct packed {
    logic              success;
    logic [DATA_W-1:0] pop_value;
  } ring_result_t;

  logic [LG_W-1:0]   ring_lg;
  logic [POS_W-1:0]  head_pos;
  logic [POS_W-1:0]  tail_pos;
  logic [POS_W-1:0]  slot_tag [MAX_SLOTS];
  logic [DATA_W-1:0] slot_data [MAX_SLOTS];
  ring_result_t      expected_results [$];

  function automatic logic [POS_W-1:0] ring_slot_count();
    logic [LG_W-1:0] lg;
    lg = ring_lg;
    if (lg == '0) begin
      lg = LG_W'(1);
    end else if (lg > LG_W'(SLOT_AW)) begin
      lg = LG_W'(SLOT_AW);
    end
    return POS_W'(1) << lg;
  endfunction

  task automatic restart_ring();
    head_pos = '0;
    tail_pos = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_tag[i] = POS_W'(i);
    end
  endtask

  function automatic ring_result_t ring_access(input logic kind,
                                               input logic [DATA_W-1:0] value);
    ring_result_t     res;
    logic [POS_W-1:0] mask;
    int unsigned      idx;
    res  = '0;
    mask = ring_slot_count() - POS_W'(1);
    if (kind == KIND_ENQ) begin
      idx = int'(head_pos & mask);
      if (slot_tag[idx] == head_pos) begin
        slot_data[idx] = value;
        slot_tag[idx]  = head_pos + POS_W'(1);
        head_pos       = head_pos + POS_W'(1);
        res.success    = 1'b1;
      end
    end else begin
      idx = int'(tail_pos & mask);
      if (slot_tag[idx] == tail_pos + POS_W'(1)) begin
        res.pop_value = slot_data[idx];
        slot_tag[idx] = tail_pos + ring_slot_count();
        tail_pos      = tail_pos + POS_W'(1);
        res.success   = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t want;
    if (!rst_ni) begin
      ring_lg = RING_LG_RESET;
      restart_ring();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_data[i] = '0;
      end
      expected_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == ADDR_W'(REG_RING_SIZE_LOG2)) begin
        ring_lg = pwdata[LG_W-1:0];
        restart_ring();
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with none expected, got success %0b pop_value %h",
                   $time, success_i, pop_value_i);
          mismatch_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (success_i !== want.success) begin
            $display("%0t: success expected %0b, got %0b", $time, want.success, success_i);
            mismatch_count_o++;
          end
          if (pop_value_i !== want.pop_value) begin
            $display("%0t: pop_value expected %h, got %h", $time, want.pop_value,
                     pop_value_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(ring_access(kind_i, push_value_i));
      end
    end
    pending_count_o = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_sequenced_ring_queue.sv -----
// Testbench top for the sequenced ring queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sequenced_ring_queue;
  import srq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned HOLD_AFTER_ITEMS = 300;
  localparam int unsigned UNMAPPED_REG     = 1;
  localparam int unsigned RANDOM_ITEMS     = 1150;
  localparam int unsigned SETTLE_CYCLES    = 8;

  typedef enum int unsigned {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [DATA_W-1:0]   push_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                success_o;
  logic [DATA_W-1:0]   pop_value_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned phase_lg [$];

  always #5 clk_i = ~clk_i;

  sequenced_ring_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .success_o    (success_o),
    .pop_value_o  (pop_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  srq_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .push_value_i     (push_value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .success_i        (success_o),
    .pop_value_i      (pop_value_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  task automatic send_item(input logic kind, input logic [DATA_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    push_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned index, input logic [PDATA_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * index);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly runs of one kind, of random length up to twice the ring size plus two
  // but at most 70, mixed with single transfers of random kind.
  task automatic run_phase(input int unsigned slots, input int unsigned count);
    int unsigned done;
    int unsigned run_len;
    logic        kind;
    logic        sweep;
    logic [DATA_W-1:0] value;
    done = 0;
    while (done < count) begin
      sweep   = ($urandom_range(0, 6) != 0);
      run_len = sweep ? $urandom_range(1, (2 * slots + 2 > 70) ? 70 : 2 * slots + 2) : 1;
      if (run_len > count - done) begin
        run_len = count - done;
      end
      kind = $urandom_range(0, 1) ? KIND_DEQ : KIND_ENQ;
      repeat (run_len) begin
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = '1;
          default: value = {$urandom, $urandom};
        endcase
        send_item(kind, value);
      end
      done += run_len;
    end
  endtask

  initial begin
    int unsigned lg;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_ENQ;
    push_value_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    items_sent   = 0;
    burst_left   = 0;
    phase_lg     = {1, 3, 0, 15, 2, 4, 6, 10, 5, 11, 1, 2, 3, 7};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Largest ring after reset: empty dequeue first, then the data extremes.
    send_item(KIND_DEQ, '1);
    send_item(KIND_ENQ, '0);
    send_item(KIND_ENQ, '1);
    send_item(KIND_ENQ, {32{2'b01}});
    send_item(KIND_ENQ, {32{2'b10}});
    send_item(KIND_DEQ, '0);
    send_item(KIND_DEQ, '1);
    // A write outside the register map must leave the ring contents alone.
    write_reg(UNMAPPED_REG, '1);
    send_item(KIND_DEQ, '0);
    send_item(KIND_DEQ, '0);
    send_item(KIND_DEQ, '0);
    // A size of zero behaves as two slots: the third enqueue finds the ring full.
    write_reg(REG_RING_SIZE_LOG2, '0);
    repeat (3) send_item(KIND_ENQ, {$urandom, $urandom});
    repeat (3) send_item(KIND_DEQ, {$urandom, $urandom});
    // An oversized setting is limited to the largest ring; a later size write
    // empties the ring even though an entry is still stored.
    write_reg(REG_RING_SIZE_LOG2, PDATA_W'(15));
    send_item(KIND_ENQ, {$urandom, $urandom});
    write_reg(REG_RING_SIZE_LOG2, PDATA_W'({$urandom, 4'd1}));
    send_item(KIND_DEQ, '0);
    send_item(KIND_ENQ, {$urandom, $urandom});
    send_item(KIND_DEQ, '0);

    foreach (phase_lg[i]) begin
      write_reg(REG_RING_SIZE_LOG2, PDATA_W'(phase_lg[i]));
      lg = (phase_lg[i] < 1) ? 1 : (phase_lg[i] > SLOT_AW) ? SLOT_AW : phase_lg[i];
      run_phase(1 << lg, RANDOM_ITEMS / phase_lg.size());
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // The receiver stalls on segments of its own, and once holds off long enough
  // for the block to fill and stall its input.
  initial begin
    int unsigned seg_len;
    rx_mode_e    mode;
    bit          hold_done;
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      seg_len = $urandom_range(1, 64);
      mode    = rx_mode_e'($urandom_range(0, 3));
      repeat (seg_len) begin
        @(posedge clk_i);
        if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_done = 1'b1;
        end
        case (mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/srq_pkg.sv
rtl/core/srq_ctrl.sv
rtl/core/srq_datapath.sv
rtl/core/sequenced_ring_queue.sv
tb/sv/srq_checker.sv
tb/sv/tb_sequenced_ring_queue.sv
